@@ rtl/fifo_evict_key_value_cache_assert.svh @@
// Assertion macros used by the cache RTL.
// Included by modules that carry concurrent assertions; needs no package.
`ifndef FIFO_EVICT_KEY_VALUE_CACHE_ASSERT_SVH
`define FIFO_EVICT_KEY_VALUE_CACHE_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define FEKV_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define FEKV_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/fekv_pkg.sv @@
// Package for the FIFO-replacement key/value cache.
// Holds operation codes, default sizes, register constants and the per-cell command type.
`timescale 1ns / 1ps

package fekv_pkg;

    // Request operation codes; the unused code behaves as a lookup.
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_ERASE  = 2'd2;

    // Default sizes of the store.
    localparam int ENTRIES_DEFAULT     = 16;
    localparam int KEY_WIDTH_DEFAULT   = 32;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // Capacity register.
    localparam int              CAP_WIDTH    = 5;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;
    localparam logic            REG_CAPACITY = 1'b0;

    // Command to one cell for the current cycle.
    typedef struct packed {
        logic take_new;   // load the request key and value
        logic take_up;    // copy the contents of the next younger cell
    } cell_op_t;

endpackage

@@ rtl/fekv_cell.sv @@
// One entry of the cache, kept in insertion order along the chain.
// Depends on fekv_pkg for the cell command type.
`timescale 1ns / 1ps

module fekv_cell #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fekv_pkg::cell_op_t     op,
    input  logic [KEY_WIDTH-1:0]   probe_key,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic                   up_valid,
    input  logic [KEY_WIDTH-1:0]   up_key,
    input  logic [VALUE_WIDTH-1:0] up_value,
    output logic                   valid,
    output logic [KEY_WIDTH-1:0]   key,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   match
);
    import fekv_pkg::*;

    logic                   valid_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;

    // Valid bit: set on a load, follows the younger neighbor on a shift.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (op.take_new) begin
            valid_reg <= 1'b1;
        end else if (op.take_up) begin
            valid_reg <= up_valid;
        end
    end

    // Key and value storage; no reset is needed since valid gates them.
    always_ff @(posedge aclk) begin
        if (op.take_new) begin
            key_reg   <= probe_key;
            value_reg <= new_value;
        end else if (op.take_up) begin
            key_reg   <= up_key;
            value_reg <= up_value;
        end
    end

    // Local key compare for the associative search.
    assign match = valid_reg && (key_reg == probe_key);
    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule

@@ rtl/fekv_ctrl.sv @@
// Request sequencer and result register of the cache.
// Depends on fekv_pkg and the assertion macro header; drives the cell chain.
`timescale 1ns / 1ps
`include "fifo_evict_key_value_cache_assert.svh"

module fekv_ctrl #(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_func,
    input  logic signed [KEY_WIDTH-1:0]          s_key,
    input  logic [VALUE_WIDTH-1:0]               s_value_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic [VALUE_WIDTH-1:0]               m_value_out,
    output logic                                 m_inserted,
    output logic                                 m_evicted,
    output logic signed [KEY_WIDTH-1:0]          m_evicted_key,
    output logic [$clog2(ENTRIES+1)-1:0]         m_occupancy,
    input  logic [fekv_pkg::CAP_WIDTH-1:0]       capacity_limit,
    input  logic [ENTRIES-1:0]                   cell_valid,
    input  logic [ENTRIES-1:0]                   cell_match,
    input  logic [KEY_WIDTH-1:0]                 cell_key [ENTRIES],
    input  logic [VALUE_WIDTH-1:0]               cell_value [ENTRIES],
    output logic [KEY_WIDTH-1:0]                 req_key,
    output logic [VALUE_WIDTH-1:0]               req_value,
    output fekv_pkg::cell_op_t                   cell_op [ENTRIES]
);
    import fekv_pkg::*;

    localparam int CountWidth = $clog2(ENTRIES + 1);
    localparam int CmpWidth   = (CountWidth > CAP_WIDTH) ? CountWidth : CAP_WIDTH;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                  state_reg;
    logic [1:0]              func_reg;
    logic [KEY_WIDTH-1:0]    key_reg;
    logic [VALUE_WIDTH-1:0]  value_reg;
    logic [CountWidth-1:0]   count_reg;
    logic [CountWidth-1:0]   count_next;
    logic                    m_valid_reg;
    logic                    found_reg;
    logic [VALUE_WIDTH-1:0]  value_out_reg;
    logic                    inserted_reg;
    logic                    evicted_reg;
    logic [KEY_WIDTH-1:0]    evicted_key_reg;
    logic [CountWidth-1:0]   occupancy_reg;

    logic                    hit;
    logic [VALUE_WIDTH-1:0]  hit_value;
    logic [CountWidth-1:0]   hit_pos;
    logic [CmpWidth-1:0]     cap_ext;
    logic [CmpWidth-1:0]     cap_eff;
    logic                    is_insert;
    logic                    is_erase;
    logic                    do_evict;
    logic                    shift_en;
    logic [CountWidth-1:0]   shift_from;
    logic [CountWidth-1:0]   load_pos;

    // Gather the single matching cell: keys are unique among valid cells.
    always_comb begin
        hit       = |cell_match;
        hit_value = '0;
        hit_pos   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (cell_match[i]) begin
                hit_value = hit_value | cell_value[i];
                hit_pos   = hit_pos | CountWidth'(i);
            end
        end
    end

    // Clamp the capacity register into the range 1 to ENTRIES.
    always_comb begin
        cap_ext = CmpWidth'(capacity_limit);
        if (cap_ext == '0) begin
            cap_eff = CmpWidth'(1);
        end else if (cap_ext > CmpWidth'(ENTRIES)) begin
            cap_eff = CmpWidth'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end

    // Decide the table update. Cell 0 holds the oldest entry, so eviction
    // and erase both shift the younger cells one step toward cell 0.
    always_comb begin
        is_insert  = (state_reg == ST_EXEC) && (func_reg == FUNC_INSERT) && !hit;
        is_erase   = (state_reg == ST_EXEC) && (func_reg == FUNC_ERASE) && hit;
        do_evict   = is_insert && (CmpWidth'(count_reg) >= cap_eff);
        shift_en   = do_evict || is_erase;
        shift_from = is_erase ? hit_pos : '0;
        load_pos   = do_evict ? (count_reg - CountWidth'(1)) : count_reg;
        count_next = count_reg;
        if (is_insert && !do_evict) begin
            count_next = count_reg + CountWidth'(1);
        end else if (is_erase) begin
            count_next = count_reg - CountWidth'(1);
        end
    end

    // Per-cell commands; a load takes priority over a shift into that cell.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            cell_op[i].take_new = is_insert && (CountWidth'(i) == load_pos);
            cell_op[i].take_up  = shift_en && (CountWidth'(i) >= shift_from) &&
                                  !cell_op[i].take_new;
        end
    end

    // A new transaction is taken in the idle state once the result register is free.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);

    // Sequencer state, occupancy count and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (s_valid && s_ready) begin
                        func_reg  <= s_func;
                        key_reg   <= s_key;
                        value_reg <= s_value_in;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    m_valid_reg     <= 1'b1;
                    found_reg       <= hit;
                    value_out_reg   <= hit_value;
                    inserted_reg    <= is_insert;
                    evicted_reg     <= do_evict;
                    evicted_key_reg <= do_evict ? cell_key[0] : '0;
                    occupancy_reg   <= count_next;
                    count_reg       <= count_next;
                    state_reg       <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_key       = key_reg;
    assign req_value     = value_reg;
    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_value_out   = value_out_reg;
    assign m_inserted    = inserted_reg;
    assign m_evicted     = evicted_reg;
    assign m_evicted_key = evicted_key_reg;
    assign m_occupancy   = occupancy_reg;

    // The valid cells always form a prefix; this checks that their number equals the count.
    `FEKV_ASSERT(a_count_matches_cells, aclk, aresetn, $countones(cell_valid) == count_reg, "cell valid bits disagree with occupancy count")
    // At most one cell may hold the requested key.
    `FEKV_ASSERT(a_single_match, aclk, aresetn, (state_reg == ST_EXEC) |-> $onehot0(cell_match), "more than one cell matched the key")
    // Every executed request leaves a result in the output register.
    `FEKV_ASSERT(a_exec_gives_result, aclk, aresetn, (state_reg == ST_EXEC) |=> m_valid_reg, "executed request produced no result")
    // The count never exceeds the number of cells.
    `FEKV_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CountWidth'(ENTRIES), "occupancy count above number of entries")

endmodule

@@ rtl/fifo_evict_key_value_cache.sv @@
// Top level of the fully associative key/value cache with FIFO replacement.
// Depends on fekv_pkg, fekv_ctrl and fekv_cell; holds the capacity register.
//
//   Channel   Prefix  Direction  Carries
//   request   s_      in         func, key, value_in
//   result    m_      out        found, value_out, inserted, evicted,
//                                evicted_key, occupancy
//   config    p       in/out     capacity_limit at byte address 0
//
// A request is registered by the accepting edge, and in the next cycle every
// cell compares its key, the hit is gathered and the chain updates.
// The next request is accepted only in the idle state, once the result register
// is empty or being taken, so no request is taken while one executes.
// Reset clears the valid bits and the count.
// A stalled result holds the request channel off until it is taken.
`timescale 1ns / 1ps

module fifo_evict_key_value_cache #(
    parameter int ENTRIES     = fekv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_WIDTH   = fekv_pkg::KEY_WIDTH_DEFAULT,
    parameter int VALUE_WIDTH = fekv_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_func,
    input  logic signed [KEY_WIDTH-1:0]   s_key,
    input  logic [VALUE_WIDTH-1:0]        s_value_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [VALUE_WIDTH-1:0]        m_value_out,
    output logic                          m_inserted,
    output logic                          m_evicted,
    output logic signed [KEY_WIDTH-1:0]   m_evicted_key,
    output logic [$clog2(ENTRIES+1)-1:0]  m_occupancy,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import fekv_pkg::*;

    logic [CAP_WIDTH-1:0]   capacity_reg;
    logic [ENTRIES-1:0]     cell_valid;
    logic [ENTRIES-1:0]     cell_match;
    logic [KEY_WIDTH-1:0]   cell_key [ENTRIES];
    logic [VALUE_WIDTH-1:0] cell_value [ENTRIES];
    logic [KEY_WIDTH-1:0]   req_key;
    logic [VALUE_WIDTH-1:0] req_value;
    cell_op_t               cell_op [ENTRIES];

    // Configuration port: writes complete in the access phase.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
            capacity_reg <= pwdata[CAP_WIDTH-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_WIDTH){1'b0}}, capacity_reg}
                                              : 32'd0;

    // Request sequencing and result register.
    fekv_ctrl #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_key          (s_key),
        .s_value_in     (s_value_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_value_out    (m_value_out),
        .m_inserted     (m_inserted),
        .m_evicted      (m_evicted),
        .m_evicted_key  (m_evicted_key),
        .m_occupancy    (m_occupancy),
        .capacity_limit (capacity_reg),
        .cell_valid     (cell_valid),
        .cell_match     (cell_match),
        .cell_key       (cell_key),
        .cell_value     (cell_value),
        .req_key        (req_key),
        .req_value      (req_value),
        .cell_op        (cell_op)
    );

    // Chain of entry cells, oldest in cell 0; each takes from its upper
    // neighbor on a shift, and the last one takes an empty slot.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic                   up_valid;
        logic [KEY_WIDTH-1:0]   up_key;
        logic [VALUE_WIDTH-1:0] up_value;

        if (g == ENTRIES - 1) begin : g_last
            assign up_valid = 1'b0;
            assign up_key   = '0;
            assign up_value = '0;
        end else begin : g_mid
            assign up_valid = cell_valid[g + 1];
            assign up_key   = cell_key[g + 1];
            assign up_value = cell_value[g + 1];
        end

        fekv_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (cell_op[g]),
            .probe_key (req_key),
            .new_value (req_value),
            .up_valid  (up_valid),
            .up_key    (up_key),
            .up_value  (up_value),
            .valid     (cell_valid[g]),
            .key       (cell_key[g]),
            .value     (cell_value[g]),
            .match     (cell_match[g])
        );
    end

endmodule

@@ dv/tb_fifo_evict_key_value_cache.sv @@
// Self-checking testbench for the FIFO-replacement key/value cache.
// Depends on fekv_pkg and the fifo_evict_key_value_cache RTL; a scoreboard class predicts results.
`timescale 1ns / 1ps

module tb_fifo_evict_key_value_cache;
    import fekv_pkg::*;

    localparam int ENTRIES = ENTRIES_DEFAULT;
    localparam int KEY_W = KEY_WIDTH_DEFAULT;
    localparam int VAL_W = VALUE_WIDTH_DEFAULT;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 6;
    localparam int POOL_DEPTH = 24;
    localparam int PHASE_ITEMS = 60;
    localparam int MAX_REPORTS = 10;

    // The unnamed operation code, which the block treats as a lookup.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0] CAP_ADDR = 3'(4 * REG_CAPACITY);

    // One result transaction as seen on the m_ channel.
    typedef struct packed {
        logic found;
        logic [VAL_W-1:0] value_out;
        logic inserted;
        logic evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [OCC_W-1:0] occupancy;
    } cache_result_t;

    // Scoreboard: keeps its own copy of the store and the queue of predicted results.
    class cache_scoreboard;
        logic [KEY_W-1:0] slot_key [ENTRIES];
        logic [VAL_W-1:0] slot_value [ENTRIES];
        bit slot_valid [ENTRIES];
        int unsigned slot_rank [ENTRIES];
        int unsigned held;
        logic [CAP_WIDTH-1:0] capacity;
        cache_result_t predicted_q [$];
        int unsigned mismatches, reported, checked;
        int unsigned n_insert, n_lookup, n_erase, n_hit, n_evict;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_rank[i] = 0;
            end
            held = 0;
            capacity = CAP_RESET;
        endfunction

        function void set_capacity(logic [CAP_WIDTH-1:0] cap);
            capacity = cap;
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        // Predicts the result of one accepted request and updates the store copy.
        function void note_request(logic [1:0] func, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value);
            cache_result_t want;
            int hit, target, cap, old_rank;
            want = '0;
            hit = -1;
            target = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
            end
            if (hit >= 0) begin
                want.found = 1'b1;
                want.value_out = slot_value[hit];
                n_hit++;
            end
            if (func == FUNC_INSERT) n_insert++;
            else if (func == FUNC_ERASE) n_erase++;
            else n_lookup++;

            if (func == FUNC_INSERT && hit < 0) begin
                cap = int'(capacity);
                if (cap < 1) cap = 1;
                if (cap > ENTRIES) cap = ENTRIES;
                // A full store gives up its oldest entry and reuses that slot.
                if (held >= cap) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (target < 0 && slot_valid[i] && slot_rank[i] == 0) target = i;
                    end
                    if (target >= 0) begin
                        want.evicted = 1'b1;
                        want.evicted_key = slot_key[target];
                        slot_valid[target] = 1'b0;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (slot_valid[i] && slot_rank[i] > 0) slot_rank[i]--;
                        end
                        held--;
                        n_evict++;
                    end
                end
                if (target < 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (target < 0 && !slot_valid[i]) target = i;
                    end
                end
                if (target >= 0) begin
                    slot_key[target] = key;
                    slot_value[target] = value;
                    slot_valid[target] = 1'b1;
                    slot_rank[target] = held;
                    held++;
                    want.inserted = 1'b1;
                end
            end else if (func == FUNC_ERASE && hit >= 0) begin
                // Younger entries close the gap so insertion order is kept.
                old_rank = slot_rank[hit];
                slot_valid[hit] = 1'b0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_valid[i] && slot_rank[i] > old_rank) slot_rank[i]--;
                end
                slot_rank[hit] = 0;
                held--;
            end
            want.occupancy = OCC_W'(held);
            predicted_q.push_back(want);
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(cache_result_t got);
            cache_result_t want;
            if (predicted_q.size() == 0) begin
                mismatches++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("unexpected result: found=%0d value=%h ins=%0d ev=%0d key=%h occ=%0d",
                             got.found, got.value_out, got.inserted, got.evicted,
                             got.evicted_key, got.occupancy);
                end
                return;
            end
            want = predicted_q.pop_front();
            checked++;
            if (got.found !== want.found || got.value_out !== want.value_out ||
                got.inserted !== want.inserted || got.evicted !== want.evicted ||
                got.evicted_key !== want.evicted_key || got.occupancy !== want.occupancy) begin
                mismatches++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("mismatch on result %0d:", checked);
                    $display("  expected found=%0d value=%h ins=%0d ev=%0d key=%h occ=%0d",
                             want.found, want.value_out, want.inserted, want.evicted,
                             want.evicted_key, want.occupancy);
                    $display("  actual   found=%0d value=%h ins=%0d ev=%0d key=%h occ=%0d",
                             got.found, got.value_out, got.inserted, got.evicted,
                             got.evicted_key, got.occupancy);
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = FUNC_LOOKUP;
    logic [KEY_W-1:0] s_key = '0;
    logic [VAL_W-1:0] s_value_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_found;
    logic [VAL_W-1:0] m_value_out;
    logic m_inserted;
    logic m_evicted;
    logic [KEY_W-1:0] m_evicted_key;
    logic [OCC_W-1:0] m_occupancy;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cache_scoreboard board = new();
    bit no_idle = 1'b0;
    int unsigned cycles = 0;
    int unsigned config_errors = 0;
    int unsigned config_writes = 0;
    logic [KEY_W-1:0] key_pool [POOL_DEPTH];

    fifo_evict_key_value_cache i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_key         (s_key),
        .s_value_in    (s_value_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_value_out   (m_value_out),
        .m_inserted    (m_inserted),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key),
        .m_occupancy   (m_occupancy),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation, 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Number of idle cycles before the next transaction on either side.
    function automatic int idle_cycles();
        if (no_idle) return 0;
        return $urandom_range(0, 16);
    endfunction

    // Result side: takes each transaction, checks it, then stalls at random.
    initial begin
        int stall_left;
        cache_result_t got;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                got.found = m_found;
                got.value_out = m_value_out;
                got.inserted = m_inserted;
                got.evicted = m_evicted;
                got.evicted_key = m_evicted_key;
                got.occupancy = m_occupancy;
                board.check_result(got);
                stall_left = idle_cycles();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Sends one request transaction; valid stays high after acceptance so a
    // back-to-back request does not drop it.
    task automatic send_request(input logic [1:0] func, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_key <= key;
        s_value_in <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_request(func, key, value);
    endtask

    // Holds the sender off until every predicted result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the capacity register over APB and reads it back.
    task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
        logic [31:0] upper;
        upper = $urandom;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= {upper[31:CAP_WIDTH], cap};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        board.set_capacity(cap);
        config_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== {{(32 - CAP_WIDTH){1'b0}}, cap}) begin
            config_errors++;
            $display("capacity readback: expected %h, got %h", cap, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random requests drawn mostly from a small key pool so hits, erases and
    // evictions all happen; the rest use fully random keys.
    task automatic run_random_phase(input int count, input int pool_used);
        int pick;
        logic [1:0] func;
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) func = FUNC_INSERT;
            else if (pick < 75) func = FUNC_LOOKUP;
            else if (pick < 93) func = FUNC_ERASE;
            else func = FUNC_UNUSED;
            if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, pool_used - 1)];
            else key = $urandom;
            send_request(func, key, $urandom);
            if ($urandom_range(0, 49) == 0) drain_results();
        end
    endtask

    // Main sequence: reset, directed cases, then random phases per capacity.
    initial begin
        logic [CAP_WIDTH-1:0] cap_plan [8];
        logic [CAP_WIDTH-1:0] cap;
        int eff, pool_used;
        cap_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd17, 5'd8, 5'd2};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty store, extreme keys, a duplicate insert, the unused
        // operation and an erase from the middle of the insertion order.
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_ERASE, 32'h1234_5678, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
        send_request(FUNC_INSERT, 32'h8000_0000, 32'h0000_1234);
        send_request(FUNC_UNUSED, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_ERASE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'h5555_5555);

        // Capacity lowered below occupancy: each new key evicts just one entry.
        drain_results();
        write_capacity(5'd2);
        send_request(FUNC_INSERT, 32'h0000_0064, 32'hDEAD_BEEF);
        send_request(FUNC_LOOKUP, 32'h0000_0064, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'h0000_0000, 32'h0F0F_0F0F);

        // Capacity of zero behaves as one.
        drain_results();
        write_capacity(5'd0);
        send_request(FUNC_INSERT, 32'h0000_00C8, 32'hCAFE_F00D);
        send_request(FUNC_ERASE, 32'h0000_00C8, 32'h0000_0000);
        send_request(FUNC_ERASE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_ERASE, 32'h0000_0064, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'h0000_012C, 32'h1111_1111);
        send_request(FUNC_INSERT, 32'h0000_012D, 32'h2222_2222);
        send_request(FUNC_LOOKUP, 32'h0000_012C, 32'h0000_0000);

        // Random phases, each with its own capacity and key pool.
        for (int p = 0; p < 8; p++) begin
            cap = (p == 7) ? CAP_WIDTH'($urandom_range(1, ENTRIES)) : cap_plan[p];
            drain_results();
            write_capacity(cap);
            eff = (int'(cap) < 1) ? 1 : (int'(cap) > ENTRIES ? ENTRIES : int'(cap));
            pool_used = (eff + 4 > POOL_DEPTH) ? POOL_DEPTH : eff + 4;
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7FFF_FFFF;
            key_pool[2] = 32'h0000_0000;
            key_pool[3] = 32'hFFFF_FFFF;
            for (int k = 4; k < POOL_DEPTH; k++) key_pool[k] = $urandom;
            for (int k = 0; k < POOL_DEPTH; k++) begin
                int j;
                logic [KEY_W-1:0] tmp;
                j = $urandom_range(0, POOL_DEPTH - 1);
                tmp = key_pool[k];
                key_pool[k] = key_pool[j];
                key_pool[j] = tmp;
            end
            no_idle = (p == 2 || p == 5);
            run_random_phase(PHASE_ITEMS, pool_used);
        end
        no_idle = 1'b0;
        drain_results();

        $display("Covered %0d requests: %0d inserts, %0d lookups, %0d erases, %0d hits.",
                 board.n_insert + board.n_lookup + board.n_erase, board.n_insert,
                 board.n_lookup, board.n_erase, board.n_hit);
        $display("%0d evictions over %0d capacity writes; %0d results checked.",
                 board.n_evict, config_writes, board.checked);
        if (board.mismatches == 0 && config_errors == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d readback errors, %0d results missing",
                     board.mismatches, config_errors, board.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
